[hw/rtl/wbhp_pkg.sv]
// Package: shared types, constants and the sample-rate table of the block header parser.
`timescale 1ns / 1ps
package wbhp_pkg;
    localparam int unsigned WinLen     = 32;
    localparam int unsigned CfgIdxW    = 1;
    localparam int unsigned CfgDataW   = 24;
    localparam logic [23:0] ResyncRst  = 24'd1048576;
    localparam logic [17:0] RateUnkVal = 18'd15;
    localparam int unsigned QueueDepth = 2;

    typedef enum logic [1:0] {
        ST_FRAME = 2'd0,
        ST_RESYNC = 2'd1,
        ST_EARLY_END = 2'd2
    } t_status;

    typedef enum logic [CfgIdxW-1:0] {
        REG_BLOCKED = 1'b0,
        REG_RESYNC = 1'b1
    } t_cfg_idx;

    // One byte as classified by the front end.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_stream;
    } t_item;

    typedef struct packed {
        logic [1:0]  status;
        logic [19:0] payload_bytes;
        logic [7:0]  chan_total;
        logic [17:0] rate_hz;
        logic        rate_unknown;
        logic [5:0]  smp_bits;
        logic [31:0] blk_samples;
        logic        hybrid_mode;
        logic        non_audio_seen;
    } t_result;

    function automatic logic [17:0] rate_lookup(input logic [3:0] idx);
        logic [17:0] r;
        case (idx)
            4'd0: r = 18'd6000;
            4'd1: r = 18'd8000;
            4'd2: r = 18'd9600;
            4'd3: r = 18'd11025;
            4'd4: r = 18'd12000;
            4'd5: r = 18'd16000;
            4'd6: r = 18'd22050;
            4'd7: r = 18'd24000;
            4'd8: r = 18'd32000;
            4'd9: r = 18'd44100;
            4'd10: r = 18'd48000;
            4'd11: r = 18'd64000;
            4'd12: r = 18'd88200;
            4'd13: r = 18'd96000;
            4'd14: r = 18'd192000;
            default: r = RateUnkVal;
        endcase
        return r;
    endfunction
endpackage

[hw/rtl/wbhp_in_if.sv]
// Interfaces: byte input channel and result output channel.
`timescale 1ns / 1ps
interface wbhp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_stream;
    modport source (output valid, data_byte, end_of_stream, input ready);
    modport sink (input valid, data_byte, end_of_stream, output ready);
endinterface

interface wbhp_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [19:0] payload_bytes;
    logic [7:0]  chan_total;
    logic [17:0] rate_hz;
    logic        rate_unknown;
    logic [5:0]  smp_bits;
    logic [31:0] blk_samples;
    logic        hybrid_mode;
    logic        non_audio_seen;
    modport source (output valid, status, payload_bytes, chan_total, rate_hz,
        rate_unknown, smp_bits, blk_samples, hybrid_mode, non_audio_seen,
        input ready);
    modport sink (input valid, status, payload_bytes, chan_total, rate_hz,
        rate_unknown, smp_bits, blk_samples, hybrid_mode, non_audio_seen,
        output ready);
endinterface

[hw/rtl/wbhp_queue.sv]
// Short byte queue between the input front end and the parser back end.
`timescale 1ns / 1ps
module wbhp_queue #(
    parameter int unsigned Depth = wbhp_pkg::QueueDepth
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  wbhp_pkg::t_item i_item,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_empty,
    output wbhp_pkg::t_item o_item
);
    import wbhp_pkg::*;
    localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;

    t_item r_mem [Depth];
    logic [AW-1:0] r_wp, r_rp;
    logic [AW:0]   r_cnt;

    function automatic logic [AW-1:0] adv(input logic [AW-1:0] p);
        return (p == AW'(Depth - 1)) ? '0 : p + 1'b1;
    endfunction

    assign o_full  = (r_cnt == (AW+1)'(Depth));
    assign o_empty = (r_cnt == '0);
    assign o_item  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_item;
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= adv(r_wp);
            if (i_pop) r_rp <= adv(r_rp);
            r_cnt <= r_cnt + (AW+1)'(i_push) - (AW+1)'(i_pop);
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n) o_full |-> !i_push)
        else $error("push into full queue");
    assert property (@(posedge i_clk) disable iff (!i_rst_n) o_empty |-> !i_pop)
        else $error("pop from empty queue");
    assert property (@(posedge i_clk) disable iff (!i_rst_n) r_cnt <= (AW+1)'(Depth))
        else $error("queue count overflow");
endmodule

[hw/rtl/wbhp_parser.sv]
// Back end: window, header check, field decode, skip and result register.
`timescale 1ns / 1ps
module wbhp_parser (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_blocked,
    input  logic [23:0]     i_resync_limit,
    input  logic            i_valid,
    input  wbhp_pkg::t_item i_item,
    output logic            o_pop,
    output logic            o_res_valid,
    input  logic            i_res_ready,
    output wbhp_pkg::t_result o_res
);
    import wbhp_pkg::*;

    logic [7:0]  r_win [WinLen];
    logic [5:0]  r_fill;
    logic        r_skip;
    logic [19:0] r_skip_rem;
    logic [24:0] r_disc;
    logic [7:0]  r_ch;
    logic [17:0] r_rate;
    logic [5:0]  r_bits;
    logic [31:0] r_samp;
    logic [1:0]  r_flags;
    logic        r_res_valid;
    t_result     r_res;

    logic [7:0]  w [WinLen];
    logic        full, hdr, leave, emit, idle_after, res_due;
    logic [31:0] size, samples, flags;
    logic [19:0] pay;
    logic [8:0]  ch_sum;
    logic [7:0]  ch_n, n_ch;
    logic [17:0] n_rate;
    logic [5:0]  n_bits;
    logic [31:0] n_samp;
    logic [1:0]  n_flags;
    logic [24:0] disc_inc;
    t_result     res;

    // Proceed when the result slot is free, being drained, or not needed by this byte.
    assign o_pop = i_valid && (!r_res_valid || i_res_ready || !res_due);
    assign o_res_valid = r_res_valid;
    assign o_res = r_res;

    always_comb begin
        for (int k = 0; k < WinLen; k++) begin
            w[k] = r_win[k];
        end
        w[r_fill[4:0]] = i_item.data_byte;
        full = (r_fill == 6'(WinLen - 1));
        hdr = w[0] == 8'h77 && w[1] == 8'h76 && w[2] == 8'h70 && w[3] == 8'h6B &&
              !w[4][0] && w[6] < 8'd16 && w[7] == 8'd0 && w[9] == 8'd4 &&
              w[8] >= 8'd2 && w[8] <= 8'hF;
        size    = {w[7], w[6], w[5], w[4]};
        samples = {w[23], w[22], w[21], w[20]};
        flags   = {w[27], w[26], w[25], w[24]};
        pay = (size >= 32'd24) ? 20'(size - 32'd24) : 20'd0;
        ch_n = flags[2] ? 8'd1 : 8'd2;
        n_ch = r_ch; n_rate = r_rate; n_bits = r_bits; n_samp = r_samp;
        n_flags = r_flags;
        leave = !i_blocked;
        ch_sum = {1'b0, r_ch} + {1'b0, ch_n};
        if (samples != 32'd0) begin
            if (flags[11]) begin
                n_rate = rate_lookup(flags[26:23]);
                n_bits = (flags[8] || flags[7]) ? 6'd32 :
                         {({1'b0, flags[1:0]} + 3'd1), 3'b000};
                n_samp = samples;
                n_ch = ch_n;
            end else begin
                n_ch = ch_sum[8] ? 8'd255 : ch_sum[7:0];
            end
            if (flags[12]) leave = 1'b1;
        end else begin
            n_flags[0] = 1'b1;
        end
        n_flags[1] = flags[3];
        disc_inc = r_disc + 25'd1;
        res = '0;
        emit = 1'b0;
        if (!r_skip && full) begin
            if (hdr && leave) begin
                emit = 1'b1;
                res.status = ST_FRAME;
                res.payload_bytes = pay;
                res.chan_total = n_ch;
                res.rate_hz = n_rate;
                res.rate_unknown = (n_rate == RateUnkVal);
                res.smp_bits = n_bits;
                res.blk_samples = n_samp;
                res.hybrid_mode = n_flags[1];
                res.non_audio_seen = n_flags[0];
            end else if (!hdr && disc_inc > {1'b0, i_resync_limit}) begin
                emit = 1'b1;
                res.status = ST_RESYNC;
            end
        end
        // Idle after this byte: hunting, empty window and nothing gathered.
        if (r_skip) begin
            idle_after = (r_skip_rem <= 20'd1) && r_ch == 8'd0 && !r_flags[0];
        end else if (full && hdr) begin
            idle_after = (pay == 20'd0) && (leave || (n_ch == 8'd0 && !n_flags[0]));
        end else begin
            idle_after = 1'b0;
        end
        // Early end unless a result is already due or the parser would be idle.
        res_due = emit;
        if (i_item.end_of_stream && !emit && !idle_after) begin
            res_due = 1'b1;
            res = '0;
            res.status = ST_EARLY_END;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < WinLen; k++) r_win[k] <= '0;
            r_fill <= '0; r_skip <= 1'b0; r_skip_rem <= '0; r_disc <= '0;
            r_ch <= '0; r_rate <= '0; r_bits <= '0; r_samp <= '0; r_flags <= '0;
            r_res_valid <= 1'b0;
            r_res <= '0;
        end else begin
            if (o_pop && res_due) begin
                r_res_valid <= 1'b1;
                r_res <= res;
            end else if (i_res_ready) begin
                r_res_valid <= 1'b0;
            end
            if (o_pop && i_item.end_of_stream) begin
                // Drop all stream state after the last byte.
                for (int k = 0; k < WinLen; k++) r_win[k] <= '0;
                r_fill <= '0; r_skip <= 1'b0; r_skip_rem <= '0; r_disc <= '0;
                r_ch <= '0; r_rate <= '0; r_bits <= '0; r_samp <= '0;
                r_flags <= '0;
            end else if (o_pop) begin
                if (r_skip) begin
                    // Advance through the payload; hunt again when it runs out.
                    if (r_skip_rem <= 20'd1) begin
                        r_skip <= 1'b0;
                        r_skip_rem <= '0;
                    end else begin
                        r_skip_rem <= r_skip_rem - 20'd1;
                    end
                end else if (!full) begin
                    r_win[r_fill[4:0]] <= i_item.data_byte;
                    r_fill <= r_fill + 6'd1;
                end else if (hdr) begin
                    r_fill <= '0;
                    r_disc <= '0;
                    r_rate <= n_rate; r_bits <= n_bits; r_samp <= n_samp;
                    r_ch <= leave ? 8'd0 : n_ch;
                    r_flags <= leave ? 2'd0 : n_flags;
                    r_skip_rem <= pay;
                    r_skip <= (pay != 20'd0);
                end else if (emit) begin
                    for (int k = 0; k < WinLen; k++) r_win[k] <= '0;
                    r_fill <= '0; r_disc <= '0; r_ch <= '0; r_flags <= '0;
                end else begin
                    // Drop the oldest byte and count it.
                    for (int k = 0; k < WinLen - 1; k++) r_win[k] <= w[k+1];
                    r_win[WinLen-1] <= '0;
                    r_disc <= disc_inc;
                end
            end
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_res_valid && !i_res_ready) |=> (r_res_valid && $stable(r_res)))
        else $error("result lost while stalled");
    assert property (@(posedge i_clk) disable iff (!i_rst_n) r_fill <= 6'(WinLen - 1))
        else $error("window fill out of range");
    assert property (@(posedge i_clk) disable iff (!i_rst_n) r_skip |-> r_fill == '0)
        else $error("skipping with a part-filled window");
endmodule

[hw/rtl/wavpack_block_header_sync_parser.sv]
// Top level: block header sync parser with decoupled input queue and parser back end.
//
//  channel | dir | handshake        | payload
//  in_ch   | in  | valid/ready      | data_byte[7:0], end_of_stream
//  out_ch  | out | valid/ready      | status, payload_bytes, ... non_audio_seen
//  cfg     | in  | i_cfg_we (no rdy)| i_cfg_idx[0], i_cfg_data[23:0]
//
// One byte per cycle sustained unless a result waiting for the sink holds the parser.
// A result appears in the output register in the cycle after its byte leaves the queue.
// A result waiting for the sink stalls the parser only at the next byte that would
// produce a result; other bytes keep flowing. The queue then fills and drops in_ch.ready.
// Synchronous active-low reset clears the queue, the window and all stream state.
`timescale 1ns / 1ps
module wavpack_block_header_sync_parser #(
    parameter int unsigned QDepth = wbhp_pkg::QueueDepth
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [wbhp_pkg::CfgIdxW-1:0]  i_cfg_idx,
    input  logic [wbhp_pkg::CfgDataW-1:0] i_cfg_data,
    wbhp_in_if.sink               in_ch,
    wbhp_out_if.source            out_ch
);
    import wbhp_pkg::*;

    logic        r_blocked;
    logic [23:0] r_resync;
    logic        q_full, q_empty, pop;
    t_item       q_in, q_out;
    t_result     res;

    // Hold configuration; writes are meant only while idle, the block itself does not enforce it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blocked <= 1'b1;
            r_resync <= ResyncRst;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                REG_BLOCKED: r_blocked <= i_cfg_data[0];
                REG_RESYNC: r_resync <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign in_ch.ready = !q_full;
    assign q_in = '{data_byte: in_ch.data_byte, end_of_stream: in_ch.end_of_stream};

    wbhp_queue #(
        .Depth(QDepth)
    ) u_queue (
        .i_clk, .i_rst_n,
        .i_push (in_ch.valid && !q_full),
        .i_item (q_in),
        .o_full (q_full),
        .i_pop  (pop),
        .o_empty(q_empty),
        .o_item (q_out)
    );

    wbhp_parser u_parser (
        .i_clk, .i_rst_n,
        .i_blocked     (r_blocked),
        .i_resync_limit(r_resync),
        .i_valid       (!q_empty),
        .i_item        (q_out),
        .o_pop         (pop),
        .o_res_valid   (out_ch.valid),
        .i_res_ready   (out_ch.ready),
        .o_res         (res)
    );

    assign out_ch.status = res.status;
    assign out_ch.payload_bytes = res.payload_bytes;
    assign out_ch.chan_total = res.chan_total;
    assign out_ch.rate_hz = res.rate_hz;
    assign out_ch.rate_unknown = res.rate_unknown;
    assign out_ch.smp_bits = res.smp_bits;
    assign out_ch.blk_samples = res.blk_samples;
    assign out_ch.hybrid_mode = res.hybrid_mode;
    assign out_ch.non_audio_seen = res.non_audio_seen;
endmodule

[tb/wbhp_frame_checker.sv]
// Checker: watches the byte and result channels, predicts each frame result and compares.
`timescale 1ns / 1ps
module wbhp_frame_checker
    import wbhp_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [CfgIdxW-1:0]  i_cfg_idx,
    input  logic [CfgDataW-1:0] i_cfg_data,
    wbhp_in_if                  in_ch,
    wbhp_out_if                 out_ch,
    output int                  o_fail_count,
    output int                  o_pending
);
    localparam logic [17:0] RATE_HZ [15] = '{
        18'd6000, 18'd8000, 18'd9600, 18'd11025, 18'd12000, 18'd16000, 18'd22050,
        18'd24000, 18'd32000, 18'd44100, 18'd48000, 18'd64000, 18'd88200, 18'd96000,
        18'd192000};

    logic [7:0]  win [32];
    int          fill;
    bit          skipping;
    logic [19:0] skip_left;
    logic [24:0] discards;
    int          chans;
    logic [17:0] rate_r;
    logic [5:0]  bits_r;
    logic [31:0] spb_r;
    logic [1:0]  seen;
    bit          blocked;
    logic [23:0] limit;
    t_result     frames_q [$];
    int          fails = 0;

    assign o_fail_count = fails;
    assign o_pending    = frames_q.size();

    function automatic void clear_stream();
        foreach (win[k]) win[k] = '0;
        fill      = 0;
        skipping  = 0;
        skip_left = '0;
        discards  = '0;
        chans     = 0;
        rate_r    = '0;
        bits_r    = '0;
        spb_r     = '0;
        seen      = '0;
    endfunction

    // advance the parser by one byte; hit says whether a result is due
    function automatic void parse_byte(input logic [7:0] b, input bit eos,
                                       output bit hit, output t_result r);
        logic [31:0] size, nsamp, flg;
        logic [19:0] pay;
        logic [3:0]  idx;
        bit          leave, idle;
        r   = '0;
        hit = 0;
        if (skipping) begin
            if (skip_left != 0) skip_left--;
            if (skip_left == 0) skipping = 0;
        end else begin
            win[fill[4:0]] = b;
            fill++;
            if (fill >= 32) begin
                if (win[0] == 8'h77 && win[1] == 8'h76 && win[2] == 8'h70 && win[3] == 8'h6B
                    && !win[4][0] && win[6] < 16 && win[7] == 0 && win[9] == 4
                    && win[8] >= 2 && win[8] <= 15) begin
                    size  = {win[7], win[6], win[5], win[4]};
                    nsamp = {win[23], win[22], win[21], win[20]};
                    flg   = {win[27], win[26], win[25], win[24]};
                    pay   = (size >= 24) ? 20'(size - 24) : '0;
                    leave = !blocked;
                    fill     = 0;
                    discards = '0;
                    if (nsamp != 0) begin
                        if (flg[11]) begin
                            idx    = flg[26:23];
                            rate_r = (idx == 4'hF) ? RateUnkVal : RATE_HZ[idx];
                            bits_r = (flg[8] || flg[7]) ? 6'd32 : 6'({flg[1:0], 3'b000} + 8);
                            spb_r  = nsamp;
                            chans  = flg[2] ? 1 : 2;
                        end else begin
                            chans += flg[2] ? 1 : 2;
                            if (chans > 255) chans = 255;
                        end
                        if (flg[12]) leave = 1;
                    end else begin
                        seen[0] = 1'b1;
                    end
                    seen[1] = flg[3];
                    if (leave) begin
                        r.status         = ST_FRAME;
                        r.payload_bytes  = pay;
                        r.chan_total     = 8'(chans);
                        r.rate_hz        = rate_r;
                        r.rate_unknown   = (rate_r == RateUnkVal);
                        r.smp_bits       = bits_r;
                        r.blk_samples    = spb_r;
                        r.hybrid_mode    = seen[1];
                        r.non_audio_seen = seen[0];
                        hit   = 1;
                        chans = 0;
                        seen  = '0;
                    end
                    skip_left = pay;
                    skipping  = (pay != 0);
                end else begin
                    // drop the oldest byte and count it against the limit
                    for (int k = 0; k < 31; k++) win[k] = win[k + 1];
                    win[31] = '0;
                    fill    = 31;
                    discards++;
                    if (discards > {1'b0, limit}) begin
                        r.status = ST_RESYNC;
                        hit      = 1;
                        foreach (win[k]) win[k] = '0;
                        fill     = 0;
                        discards = '0;
                        chans    = 0;
                        seen     = '0;
                    end
                end
            end
        end
        if (eos) begin
            idle = !skipping && fill == 0 && chans == 0 && !seen[0];
            if (!hit && !idle) begin
                r        = '0;
                r.status = ST_EARLY_END;
                hit      = 1;
            end
            clear_stream();
        end
    endfunction

    task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch: expected 0x%0h, got 0x%0h", $time, name, want, got);
            fails++;
        end
    endtask

    always @(posedge i_clk) begin
        t_result want, pred;
        bit      hit;
        if (!i_rst_n) begin
            blocked = 1;
            limit   = ResyncRst;
            clear_stream();
            frames_q.delete();
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (frames_q.size() == 0) begin
                    $display("%0t: unexpected result: expected none, got status %0d",
                             $time, out_ch.status);
                    fails++;
                end else begin
                    want = frames_q.pop_front();
                    check_field("status", want.status, out_ch.status);
                    check_field("payload_bytes", want.payload_bytes, out_ch.payload_bytes);
                    check_field("chan_total", want.chan_total, out_ch.chan_total);
                    check_field("rate_hz", want.rate_hz, out_ch.rate_hz);
                    check_field("rate_unknown", want.rate_unknown, out_ch.rate_unknown);
                    check_field("smp_bits", want.smp_bits, out_ch.smp_bits);
                    check_field("blk_samples", want.blk_samples, out_ch.blk_samples);
                    check_field("hybrid_mode", want.hybrid_mode, out_ch.hybrid_mode);
                    check_field("non_audio_seen", want.non_audio_seen, out_ch.non_audio_seen);
                end
            end
            if (i_cfg_we) begin
                if (i_cfg_idx == REG_BLOCKED) blocked = i_cfg_data[0];
                else limit = i_cfg_data;
            end
            if (in_ch.valid && in_ch.ready) begin
                parse_byte(in_ch.data_byte, in_ch.end_of_stream, hit, pred);
                if (hit) frames_q.push_back(pred);
            end
        end
    end
endmodule

[tb/wavpack_block_header_sync_parser_tb.sv]
// Testbench top: builds block streams, drives the parser and gives the verdict.
`timescale 1ns / 1ps
module wavpack_block_header_sync_parser_tb;
    import wbhp_pkg::*;

    // header flag bits
    localparam logic [31:0] FlgMono    = 32'h4;
    localparam logic [31:0] FlgHybrid  = 32'h8;
    localparam logic [31:0] FlgFloat   = 32'h80;
    localparam logic [31:0] FlgInt32   = 32'h100;
    localparam logic [31:0] FlgInitial = 32'h800;
    localparam logic [31:0] FlgFinal   = 32'h1000;
    localparam int          RateLsb    = 23;
    localparam int          LongHold   = 400;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_cfg_we = 1'b0;
    logic [CfgIdxW-1:0]  i_cfg_idx = REG_BLOCKED;
    logic [CfgDataW-1:0] i_cfg_data = '0;

    wbhp_in_if  in_ch ();
    wbhp_out_if out_ch ();

    int fail_count, pending;
    int tx_gap_pct = 6;
    int rx_stall_pct = 57;
    int sent_bytes = 0;
    bit hold_req = 0;
    int hold_left = 0;
    logic [8:0] stream_q [$];   // {byte, end of stream}

    wavpack_block_header_sync_parser i_dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    wbhp_frame_checker i_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .in_ch       (in_ch),
        .out_ch      (out_ch),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Result side: random stalls, plus one long hold-off on request so the
    // parser backs up and stalls its input.
    initial begin
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_left = LongHold;
                hold_req  = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    task automatic put(input logic [7:0] b);
        stream_q.push_back({b, 1'b0});
    endtask

    task automatic put_word(input logic [31:0] w);
        for (int k = 0; k < 4; k++) put(w[8*k +: 8]);
    endtask

    // one 32-byte header followed by its payload
    task automatic add_block(input logic [31:0] size, input logic [7:0] ver,
                             input logic [31:0] nsamp, input logic [31:0] flg);
        int pay;
        pay = (size >= 24) ? int'(size) - 24 : 0;
        put(8'h77); put(8'h76); put(8'h70); put(8'h6B);
        put_word(size);
        put(ver);
        put(8'h04);
        repeat (10) put(8'($urandom));
        put_word(nsamp);
        put_word(flg);
        repeat (4) put(8'($urandom));
        repeat (pay) put(8'($urandom));
    endtask

    // spoil one header field of the block that starts at pos
    task automatic spoil_header(input int pos);
        case ($urandom_range(5))
            0: stream_q[pos + $urandom_range(3)] ^= {9'h1 << $urandom_range(1, 8)};
            1: stream_q[pos + 4][1] = 1'b1;
            2: stream_q[pos + 8] = {($urandom_range(1) ? 8'h01 : 8'h10), 1'b0};
            3: stream_q[pos + 7] = {8'($urandom_range(1, 255)), 1'b0};
            4: stream_q[pos + 6] = {8'($urandom_range(16, 255)), 1'b0};
            default: stream_q[pos + 9] = {8'h05, 1'b0};
        endcase
    endtask

    // send the built stream, marking its last byte as end of stream
    task automatic send_stream(input int cut);
        logic [8:0] it;
        repeat (cut) if (stream_q.size() > 1) void'(stream_q.pop_back());
        stream_q[stream_q.size() - 1][0] = 1'b1;
        while (stream_q.size() != 0) begin
            it = stream_q.pop_front();
            if ($urandom_range(99) < tx_gap_pct) begin
                in_ch.valid <= 1'b0;
                @(posedge i_clk);
                while ($urandom_range(99) < tx_gap_pct) @(posedge i_clk);
            end
            in_ch.valid         <= 1'b1;
            in_ch.data_byte     <= it[8:1];
            in_ch.end_of_stream <= it[0];
            @(posedge i_clk);
            while (!in_ch.ready) @(posedge i_clk);
            sent_bytes++;
        end
        in_ch.valid <= 1'b0;
    endtask

    // wait until every result is in, then let trailing bytes drain
    task automatic wait_idle();
        while (pending != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CfgDataW-1:0] val);
        wait_idle();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic gen_frame();
        int          nblk, pos;
        logic [31:0] size, flg, nsamp;
        if ($urandom_range(4) == 0) repeat ($urandom_range(1, 40)) put(8'($urandom));
        nblk = $urandom_range(1, 3);
        for (int i = 0; i < nblk; i++) begin
            if ($urandom_range(99) == 0) size = 32'($urandom_range(600, 1000) & ~1);
            else if ($urandom_range(9) == 0) size = 32'($urandom_range(0, 23) & ~1);
            else size = 32'($urandom_range(24, 72) & ~1);
            flg     = $urandom;
            flg[11] = (i == 0) ? ($urandom_range(9) != 0) : ($urandom_range(9) == 0);
            flg[12] = (i == nblk - 1);
            nsamp   = ($urandom_range(9) == 0) ? '0 : $urandom;
            pos     = stream_q.size();
            add_block(size, 8'($urandom_range(2, 15)), nsamp, flg);
            if ($urandom_range(99) < 8) spoil_header(pos);
        end
    endtask

    task automatic gen_stream();
        if ($urandom_range(19) == 0) begin
            repeat ($urandom_range(1, 80)) put(8'($urandom));
        end else begin
            repeat ($urandom_range(1, 2)) gen_frame();
        end
        send_stream(($urandom_range(99) < 15) ? $urandom_range(1, 40) : 0);
    endtask

    initial begin
        logic [23:0] lim;
        in_ch.valid         <= 1'b0;
        in_ch.data_byte     <= '0;
        in_ch.end_of_stream <= 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: single initial+final block, stereo 16-bit, 44.1 kHz
        add_block(32, 8'h02, 32'd4410, FlgInitial | FlgFinal | (32'd9 << RateLsb) | 32'h1);
        send_stream(0);
        // Gathered frame: middle mono block, a zero-sample block, hybrid int32 final,
        // unknown rate index
        add_block(40, 8'h0F, 32'hFFFFFFFF, FlgInitial | (32'd15 << RateLsb) | FlgInt32);
        add_block(26, 8'h07, 32'd1, FlgMono);
        add_block(24, 8'h04, 32'd0, FlgFinal);
        add_block(30, 8'h04, 32'd9, FlgFinal | FlgHybrid | FlgInt32);
        send_stream(0);
        // Header size below 24 clamps the payload; float data, top rate; end on header
        add_block(0, 8'h03, 32'd1, FlgInitial | FlgFinal | FlgFloat | (32'd14 << RateLsb));
        send_stream(0);
        // Stream ends in the middle of a header, then a lone byte stream
        add_block(24, 8'h04, 32'd5, FlgInitial | FlgFinal);
        send_stream(10);
        put(8'hFF);
        send_stream(0);
        // Channel count gathers over several stereo blocks; lowest rate, 8-bit
        add_block(24, 8'h04, 32'd7, FlgInitial);
        repeat (3) add_block(24, 8'h04, 32'd7, '0);
        add_block(24, 8'h04, 32'd7, FlgFinal | FlgHybrid);
        send_stream(0);
        // Zero resync limit: every discarded byte fails the hunt
        write_reg(REG_RESYNC, '0);
        repeat (40) put(8'h00);
        send_stream(0);
        // Frame mode off: report after every header, widest limit
        write_reg(REG_BLOCKED, '0);
        write_reg(REG_RESYNC, 24'hFFFFFF);
        repeat (5) put(8'hAA);
        add_block(28, 8'h04, 32'd3, FlgInitial | FlgMono | (32'd3 << RateLsb));
        add_block(26, 8'h04, 32'd3, FlgMono);
        send_stream(0);

        // Random part, in three idling phases
        for (int p = 0; p < 3; p++) begin
            tx_gap_pct   = (p == 0) ? 6 : (p == 1) ? 57 : 0;
            rx_stall_pct = (p == 0) ? 57 : (p == 1) ? 6 : 0;
            for (int c = 0; c < 2; c++) begin
                case ($urandom_range(4))
                    0: lim = '0;
                    1: lim = 24'($urandom_range(1, 64));
                    2: lim = ResyncRst;
                    3: lim = 24'hFFFFFF;
                    default: lim = 24'($urandom_range(0, 24'hFFFFFF));
                endcase
                write_reg(REG_BLOCKED, CfgDataW'($urandom_range(1)));
                write_reg(REG_RESYNC, lim);
                sent_bytes = 0;
                while (sent_bytes < 120) begin
                    gen_stream();
                    if (p == 0 && c == 0 && !hold_req && hold_left == 0 && sent_bytes < 100)
                        hold_req = 1;
                end
            end
        end

        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #10ms;
        $display("Regression FAIL");
        $finish;
    end
endmodule
